// File: rtl/trsb_pkg.sv
package trsb_pkg;

  // framing and escape codes
  localparam logic [7:0] FRAME_MARK   = 8'h5E;
  localparam logic [7:0] ESCAPE_MARK  = 8'h5D;
  localparam logic [7:0] ESC_OF_FRAME = 8'h3E;
  localparam logic [7:0] ESC_OF_ESC   = 8'h3D;

  // number of stuffed data bytes per record (id, value low, value high)
  localparam int unsigned NUM_DATA = 3;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // input request
  typedef struct packed {
    logic [7:0]  data_id;
    logic [15:0] value;
    logic        end_frame;
  } in_t;

  // output byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  // classified record: first byte of each data byte, its escape flag and second byte
  typedef struct packed {
    logic [NUM_DATA-1:0]            esc;
    logic [NUM_DATA-1:0][7:0]       first;
    logic [NUM_DATA-1:0][7:0]       second;
    logic                           tail;
  } cls_t;

  // back end sequencer phases
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_FIRST,
    PH_SECOND,
    PH_TAIL
  } phase_e;

endpackage

// File: rtl/trsb_front.sv
module trsb_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  trsb_pkg::in_t  in_req_i,
  output logic           push_o,
  input  logic           full_i,
  output trsb_pkg::cls_t cls_o
);

  logic [trsb_pkg::NUM_DATA-1:0][7:0] raw;

  // data bytes in send order
  assign raw[0] = in_req_i.data_id;
  assign raw[1] = in_req_i.value[7:0];
  assign raw[2] = in_req_i.value[15:8];

  // classify each data byte against the two marks
  always_comb begin
    for (int i = 0; i < trsb_pkg::NUM_DATA; i++) begin
      if (raw[i] == trsb_pkg::FRAME_MARK) begin
        cls_o.esc[i]    = 1'b1;
        cls_o.first[i]  = trsb_pkg::ESCAPE_MARK;
        cls_o.second[i] = trsb_pkg::ESC_OF_FRAME;
      end else if (raw[i] == trsb_pkg::ESCAPE_MARK) begin
        cls_o.esc[i]    = 1'b1;
        cls_o.first[i]  = trsb_pkg::ESCAPE_MARK;
        cls_o.second[i] = trsb_pkg::ESC_OF_ESC;
      end else begin
        cls_o.esc[i]    = 1'b0;
        cls_o.first[i]  = raw[i];
        cls_o.second[i] = trsb_pkg::ESC_OF_ESC;
      end
    end
    cls_o.tail = in_req_i.end_frame;
  end

  // request handshake into the queue
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// File: rtl/trsb_queue.sv
module trsb_queue #(
  parameter int unsigned Depth = trsb_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  trsb_pkg::cls_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output trsb_pkg::cls_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  trsb_pkg::cls_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/trsb_back.sv
module trsb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  trsb_pkg::cls_t  q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output trsb_pkg::out_t  out_rsp_o
);

  localparam logic [1:0] LastIdx = 2'(trsb_pkg::NUM_DATA - 1);

  trsb_pkg::phase_e state_q, state_d;
  logic [1:0]       idx_q, idx_d;
  logic             out_valid_q;
  trsb_pkg::out_t   out_q, out_d;
  logic             adv;

  // one byte per cycle whenever a record is queued and the output register is free
  assign adv = (state_q != trsb_pkg::PH_HEAD || q_valid_i) && (!out_valid_q || out_ready_i);

  // sequencer: next phase and the byte it produces
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    out_d   = out_q;
    q_pop_o = 1'b0;
    if (adv) begin
      case (state_q)
        trsb_pkg::PH_HEAD: begin
          out_d.out_byte  = trsb_pkg::FRAME_MARK;
          out_d.last_byte = 1'b0;
          idx_d           = '0;
          state_d         = trsb_pkg::PH_FIRST;
        end
        trsb_pkg::PH_FIRST: begin
          out_d.out_byte  = q_data_i.first[idx_q];
          out_d.last_byte = 1'b0;
          if (q_data_i.esc[idx_q]) begin
            state_d = trsb_pkg::PH_SECOND;
          end else if (idx_q == LastIdx) begin
            if (q_data_i.tail) begin
              state_d = trsb_pkg::PH_TAIL;
            end else begin
              out_d.last_byte = 1'b1;
              q_pop_o         = 1'b1;
              state_d         = trsb_pkg::PH_HEAD;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        trsb_pkg::PH_SECOND: begin
          out_d.out_byte  = q_data_i.second[idx_q];
          out_d.last_byte = 1'b0;
          if (idx_q == LastIdx) begin
            if (q_data_i.tail) begin
              state_d = trsb_pkg::PH_TAIL;
            end else begin
              out_d.last_byte = 1'b1;
              q_pop_o         = 1'b1;
              state_d         = trsb_pkg::PH_HEAD;
            end
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = trsb_pkg::PH_FIRST;
          end
        end
        trsb_pkg::PH_TAIL: begin
          out_d.out_byte  = trsb_pkg::FRAME_MARK;
          out_d.last_byte = 1'b1;
          q_pop_o         = 1'b1;
          state_d         = trsb_pkg::PH_HEAD;
        end
        default: begin
          state_d = trsb_pkg::PH_HEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trsb_pkg::PH_HEAD;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output byte register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // a record leaves the queue only with its final byte
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> out_d.last_byte)
    else $error("queue popped on a byte that is not last");

  // queue head must stay present while a record is being sent
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != trsb_pkg::PH_HEAD) |-> q_valid_i)
    else $error("record left the queue mid-sequence");

  // a record always starts with the frame mark
  a_header_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && state_q == trsb_pkg::PH_HEAD) |=> (out_q.out_byte == trsb_pkg::FRAME_MARK))
    else $error("record did not start with the frame mark");

  // the data index never runs past the last data byte
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trsb_pkg::PH_FIRST || state_q == trsb_pkg::PH_SECOND) |-> (idx_q <= LastIdx))
    else $error("data index out of range");

endmodule

// File: rtl/telemetry_record_byte_stuffer.sv
// Telemetry record byte stuffer. Each accepted request (data id, 16-bit value,
// end-of-frame flag) is sent as a frame mark 0x5E, then the id, the value's low
// byte and its high byte, each escaped (0x5E -> 0x5D 0x3E, 0x5D -> 0x5D 0x3D),
// and, when end_frame is set, a closing 0x5E; last_byte marks the final byte of
// each request. A request produces 4 to 8 bytes and the back end sequencer
// emits one byte per cycle while a request is queued and the output register
// is free, with no gaps between queued requests. The front end classifies
// requests and stores them in a QueueDepth-entry queue, so up to QueueDepth
// requests, the one being sent included, are held while bytes are sent or
// stalled; the first byte passes through the queue and then the output register.
module telemetry_record_byte_stuffer #(
  parameter int unsigned QueueDepth = trsb_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  trsb_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output trsb_pkg::out_t out_rsp_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  trsb_pkg::cls_t cls_w;
  trsb_pkg::cls_t cls_r;

  // accept and classify
  trsb_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .full_i     (full),
    .cls_o      (cls_w)
  );

  // decoupling queue
  trsb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls_w),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (cls_r)
  );

  // byte sequencer and output register
  trsb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (cls_r),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
